// ===== rtl/core/med3_pkg.sv =====
// ----------------------------------------------------------------------------
// med3_pkg
// Shared types and constants of the streaming 3x3 median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package med3_pkg;

  // Configuration register widths and indexes
  localparam int LINE_W    = 11;
  localparam int ROW_W     = 12;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS  = 1'b1;

  localparam int LINE_RST = 640;
  localparam int ROWS_RST = 480;

  // Job queue between the window front and the median back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // Results released by one request, lowest bit goes out first
  typedef struct packed {
    logic last_end;   // (R, C) with right and bottom replication
    logic last_mid;   // (R, C-1) with bottom replication
    logic up_end;     // (R-1, C) with right replication
    logic up_mid;     // (R-1, C-1)
  } med3_emit_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    med3_emit_t       emit;
  } med3_tag_t;

endpackage

`default_nettype wire

// ===== rtl/core/med3_front.sv =====
// ----------------------------------------------------------------------------
// med3_front
// Accepts pixels, keeps the two line stores and the 3x3 window, and queues
// one job per request that releases results.
// ----------------------------------------------------------------------------
`default_nettype none

module med3_front
  import med3_pkg::*;
#(
  parameter int MAX_LINE   = 1024,
  parameter int PIXEL_BITS = 8,
  parameter int COL_W      = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_W-1:0]              cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [PIXEL_BITS-1:0]         in_pixel,
  input  wire logic [Q_CNT_W-1:0]            q_level,
  output logic                               push,
  output med3_tag_t                          push_tag,
  output logic [COL_W-1:0]                   push_col,
  output logic [8:0][PIXEL_BITS-1:0]         push_win
);

  localparam int RST_LEN = (LINE_RST > MAX_LINE) ? MAX_LINE : LINE_RST;

  logic [PIXEL_BITS-1:0] prior_mem [MAX_LINE];
  logic [PIXEL_BITS-1:0] older_mem [MAX_LINE];

  logic [COL_W-1:0]            last_col_r;
  logic [ROW_W-1:0]            last_row_r;
  logic [COL_W-1:0]            col_r;
  logic [ROW_W-1:0]            row_r;
  logic                        s1_valid_r;
  logic [PIXEL_BITS-1:0]       s1_px_r;
  logic [COL_W-1:0]            s1_c_r;
  logic [ROW_W-1:0]            s1_row_r;
  logic                        s1_end_r;
  logic                        s1_last_r;
  logic                        s1_zero_r;
  logic                        fwd_p_r;
  logic                        fwd_o_r;
  logic [PIXEL_BITS-1:0]       fwd_pv_r;
  logic [PIXEL_BITS-1:0]       fwd_ov_r;
  logic [PIXEL_BITS-1:0]       prior_rd_r;
  logic [PIXEL_BITS-1:0]       older_rd_r;
  logic [8:0][PIXEL_BITS-1:0]  win_r;
  logic [8:0][PIXEL_BITS-1:0]  win_nxt;

  logic [LINE_W-1:0]     len_val;
  logic [ROW_W-1:0]      rows_val;
  logic [COL_W-1:0]      last_col_cfg;
  logic [ROW_W-1:0]      last_row_cfg;
  logic                  acc;
  logic                  row_end0;
  logic                  last_row0;
  logic [COL_W-1:0]      c0;
  logic                  hit;
  logic [Q_CNT_W:0]      occ;
  logic [PIXEL_BITS-1:0] prior_v;
  logic [PIXEL_BITS-1:0] older_v;
  logic [PIXEL_BITS-1:0] mid_v;
  logic [PIXEL_BITS-1:0] top_v;
  logic                  ge1;
  logic                  ge2;
  med3_emit_t            emit;

  // Register decode: zero acts as one, oversize lines clamp to the store
  always_comb begin
    len_val  = cfg_wdata[LINE_W-1:0];
    rows_val = cfg_wdata[ROW_W-1:0];
    if (len_val == '0) begin
      last_col_cfg = '0;
    end else if (32'(len_val) > MAX_LINE) begin
      last_col_cfg = COL_W'(MAX_LINE - 1);
    end else begin
      last_col_cfg = COL_W'(len_val - 1'b1);
    end
    last_row_cfg = (rows_val == '0) ? '0 : (rows_val - 1'b1);
  end

  // Stage 0: accept, position decode, line store read
  always_comb begin
    occ       = {1'b0, q_level} + {{Q_CNT_W{1'b0}}, s1_valid_r};
    in_ready  = (occ < (Q_CNT_W+1)'(Q_DEPTH));
    acc       = in_valid && in_ready;
    row_end0  = (col_r >= last_col_r);
    c0        = row_end0 ? last_col_r : col_r;
    last_row0 = (row_r >= last_row_r);
    hit       = s1_valid_r && (s1_c_r == c0);
  end

  // Stage 1: resolve column, write back, update window
  always_comb begin
    prior_v = fwd_p_r ? fwd_pv_r : prior_rd_r;
    older_v = fwd_o_r ? fwd_ov_r : older_rd_r;
    ge1     = (s1_row_r != '0);
    ge2     = |s1_row_r[ROW_W-1:1];
    mid_v   = ge1 ? prior_v : s1_px_r;
    top_v   = ge2 ? older_v : mid_v;
    if (s1_zero_r) begin
      win_nxt = {{3{s1_px_r}}, {3{mid_v}}, {3{top_v}}};
    end else begin
      win_nxt    = win_r;
      win_nxt[0] = win_r[1];
      win_nxt[1] = win_r[2];
      win_nxt[3] = win_r[4];
      win_nxt[4] = win_r[5];
      win_nxt[6] = win_r[7];
      win_nxt[7] = win_r[8];
      win_nxt[2] = top_v;
      win_nxt[5] = mid_v;
      win_nxt[8] = s1_px_r;
    end
    emit.up_mid   = ge1 && !s1_zero_r;
    emit.up_end   = ge1 && s1_end_r;
    emit.last_mid = s1_last_r && !s1_zero_r;
    emit.last_end = s1_last_r && s1_end_r;
    push          = s1_valid_r && (emit != '0);
    push_tag.row  = s1_row_r;
    push_tag.emit = emit;
    push_col      = s1_c_r;
    push_win      = win_nxt;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      prior_rd_r <= prior_mem[c0];
    end
    if (s1_valid_r) begin
      prior_mem[s1_c_r] <= s1_px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      older_rd_r <= older_mem[c0];
    end
    if (s1_valid_r && ge1) begin
      older_mem[s1_c_r] <= prior_v;
    end
  end

  // Payload of stage 1; bypass a write that lands in the read cycle
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_px_r   <= in_pixel;
      s1_c_r    <= c0;
      s1_row_r  <= row_r;
      s1_end_r  <= row_end0;
      s1_last_r <= last_row0;
      s1_zero_r <= (c0 == '0);
      fwd_p_r   <= hit;
      fwd_o_r   <= hit && ge1;
      fwd_pv_r  <= s1_px_r;
      fwd_ov_r  <= prior_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r <= COL_W'(RST_LEN - 1);
      last_row_r <= ROW_W'(ROWS_RST - 1);
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      win_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LINE_LENGTH: last_col_r <= last_col_cfg;
          CFG_FRAME_ROWS:  last_row_r <= last_row_cfg;
          default: ;
        endcase
      end
      s1_valid_r <= acc;
      if (acc) begin
        if (row_end0) begin
          col_r <= '0;
          row_r <= last_row0 ? '0 : (row_r + 1'b1);
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
      if (s1_valid_r) begin
        win_r <= win_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/med3_queue.sv =====
// ----------------------------------------------------------------------------
// med3_queue
// Short job queue between the window front and the median back.
// ----------------------------------------------------------------------------
`default_nettype none

module med3_queue
  import med3_pkg::*;
#(
  parameter int PIXEL_BITS = 8,
  parameter int COL_W      = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire med3_tag_t                     push_tag,
  input  wire logic [COL_W-1:0]              push_col,
  input  wire logic [8:0][PIXEL_BITS-1:0]    push_win,
  input  wire logic                          pop,
  output logic                               head_valid,
  output med3_tag_t                          head_tag,
  output logic [COL_W-1:0]                   head_col,
  output logic [8:0][PIXEL_BITS-1:0]         head_win,
  output logic [Q_CNT_W-1:0]                 level
);

  med3_tag_t                  tag_mem [Q_DEPTH];
  logic [COL_W-1:0]           col_mem [Q_DEPTH];
  logic [8:0][PIXEL_BITS-1:0] win_mem [Q_DEPTH];

  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] level_r;
  logic [Q_CNT_W-1:0] level_nxt;

  always_comb begin
    level_nxt = level_r + {{(Q_CNT_W-1){1'b0}}, push} - {{(Q_CNT_W-1){1'b0}}, pop};
    level      = level_r;
    head_valid = (level_r != '0);
    head_tag   = tag_mem[rd_ptr_r];
    head_col   = col_mem[rd_ptr_r];
    head_win   = win_mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      tag_mem[wr_ptr_r] <= push_tag;
      col_mem[wr_ptr_r] <= push_col;
      win_mem[wr_ptr_r] <= push_win;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      level_r <= level_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/med3_back.sv =====
// ----------------------------------------------------------------------------
// med3_back
// Expands each job into its results and runs them through a three stage
// median-of-nine pipeline with a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module med3_back
  import med3_pkg::*;
#(
  parameter int PIXEL_BITS = 8,
  parameter int COL_W      = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          head_valid,
  input  wire med3_tag_t                     head_tag,
  input  wire logic [COL_W-1:0]              head_col,
  input  wire logic [8:0][PIXEL_BITS-1:0]    head_win,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [PIXEL_BITS-1:0]              out_median,
  output logic [ROW_W-1:0]                   out_row,
  output logic [COL_W-1:0]                   out_col,
  output logic                               out_run_last,
  output logic                               out_frame_end
);

  typedef logic [PIXEL_BITS-1:0] pix_t;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // Returns {hi, mid, lo}
  function automatic logic [2:0][PIXEL_BITS-1:0] sort3(input logic [2:0][PIXEL_BITS-1:0] v);
    pix_t lo1;
    pix_t hi1;
    pix_t t;
    logic [2:0][PIXEL_BITS-1:0] s;
    lo1  = min2(v[0], v[1]);
    hi1  = max2(v[0], v[1]);
    t    = max2(lo1, v[2]);
    s[0] = min2(lo1, v[2]);
    s[1] = min2(hi1, t);
    s[2] = max2(hi1, t);
    return s;
  endfunction

  logic                             adv;
  logic                             issue;
  logic [3:0]                       done_r;
  logic [3:0]                       pend;
  logic [3:0]                       pick;
  logic [3:0]                       rest;
  logic                             end_col;
  logic                             last_rows;
  logic [2:0][2:0][PIXEL_BITS-1:0]  a_win_nxt;
  logic [ROW_W-1:0]                 a_row_nxt;
  logic [COL_W-1:0]                 a_col_nxt;

  logic                             a_valid_r;
  logic [2:0][2:0][PIXEL_BITS-1:0]  a_win_r;
  logic [ROW_W-1:0]                 a_row_r;
  logic [COL_W-1:0]                 a_col_r;
  logic                             a_last_r;
  logic                             a_fend_r;

  logic                             b_valid_r;
  logic [2:0][2:0][PIXEL_BITS-1:0]  b_sort_r;
  logic [ROW_W-1:0]                 b_row_r;
  logic [COL_W-1:0]                 b_col_r;
  logic                             b_last_r;
  logic                             b_fend_r;

  pix_t                             lo_max;
  pix_t                             mid_med;
  pix_t                             hi_min;

  logic                             out_valid_r;
  pix_t                             out_median_r;
  logic [ROW_W-1:0]                 out_row_r;
  logic [COL_W-1:0]                 out_col_r;
  logic                             out_last_r;
  logic                             out_fend_r;

  // Sequencer: take the oldest pending result of the head job
  always_comb begin
    logic [1:0] ri;
    logic [1:0] cj;
    logic [3:0] idx;
    adv       = !out_valid_r || out_ready;
    issue     = head_valid && adv;
    pend      = head_tag.emit & ~done_r;
    pick      = pend & (~pend + 4'd1);
    rest      = pend & ~pick;
    pop       = issue && (rest == '0);
    end_col   = pick[1] | pick[3];
    last_rows = pick[2] | pick[3];
    a_row_nxt = (pick[0] | pick[1]) ? (head_tag.row - 1'b1) : head_tag.row;
    a_col_nxt = end_col ? head_col : (head_col - 1'b1);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ri  = last_rows ? ((i == 0) ? 2'd1 : 2'd2) : 2'(i);
        cj  = end_col ? ((j == 0) ? 2'd1 : 2'd2) : 2'(j);
        idx = {2'b00, ri} * 4'd3 + {2'b00, cj};
        a_win_nxt[i][j] = head_win[idx];
      end
    end
  end

  // Final stage: max of row minima, median of row medians, min of row maxima
  always_comb begin
    lo_max  = max2(max2(b_sort_r[0][0], b_sort_r[1][0]), b_sort_r[2][0]);
    mid_med = med3(b_sort_r[0][1], b_sort_r[1][1], b_sort_r[2][1]);
    hi_min  = min2(min2(b_sort_r[0][2], b_sort_r[1][2]), b_sort_r[2][2]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_win_r      <= a_win_nxt;
      a_row_r      <= a_row_nxt;
      a_col_r      <= a_col_nxt;
      a_last_r     <= (rest == '0);
      a_fend_r     <= pick[3];
      for (int i = 0; i < 3; i++) begin
        b_sort_r[i] <= sort3(a_win_r[i]);
      end
      b_row_r      <= a_row_r;
      b_col_r      <= a_col_r;
      b_last_r     <= a_last_r;
      b_fend_r     <= a_fend_r;
      out_median_r <= med3(lo_max, mid_med, hi_min);
      out_row_r    <= b_row_r;
      out_col_r    <= b_col_r;
      out_last_r   <= b_last_r;
      out_fend_r   <= b_fend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue) begin
        done_r <= (rest == '0) ? '0 : (done_r | pick);
      end
      if (adv) begin
        a_valid_r   <= issue;
        b_valid_r   <= a_valid_r;
        out_valid_r <= b_valid_r;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_median    = out_median_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_run_last  = out_last_r;
  assign out_frame_end = out_fend_r;

endmodule

`default_nettype wire

// ===== rtl/core/median_filter_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// median_filter_3x3_unit
// Streaming 3x3 median filter over a raster pixel stream with border
// replication; each result carries its row and column.
// ----------------------------------------------------------------------------
//
//  Port group  Dir  Handshake              Carries
//  in_*        in   in_valid / in_ready    in_pixel_in
//  out_*       out  out_valid / out_ready  out_median_out, out_row, out_col,
//                                          out_run_last, out_frame_end
//  cfg_*       in   cfg_we, no wait        cfg_index, cfg_wdata
//
//  Takes one pixel per clock while in_ready is high. A request releases
//  up to four results: one per pixel past column 0 of an inner row, one
//  more at a row end, and twice that on the last row; row 0 releases none
//  unless it is the last. The median pipeline issues one result per clock
//  while out_ready does not stall it; input waits only when the job queue
//  plus the job being built hold four jobs. A result lags one row and one
//  column behind the input stream.
//  Reset (synchronous, rst_n low) clears counters, pipeline, queue and sets
//  line_length 640, frame_rows 480. Line stores are not cleared.
//  A stall on out_ready freezes the median pipeline only; the queue absorbs
//  the front until it fills.
//
`default_nettype none

module median_filter_3x3_unit
  import med3_pkg::*;
#(
  parameter int MAX_LINE   = 1024,
  parameter int PIXEL_BITS = 8,
  localparam int COL_W     = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_wdata,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [PIXEL_BITS-1:0]  in_pixel_in,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [PIXEL_BITS-1:0]       out_median_out,
  output logic [ROW_W-1:0]            out_row,
  output logic [COL_W-1:0]            out_col,
  output logic                        out_run_last,
  output logic                        out_frame_end
);

  // Front to queue
  logic                        push;
  med3_tag_t                   push_tag;
  logic [COL_W-1:0]            push_col;
  logic [8:0][PIXEL_BITS-1:0]  push_win;
  logic [Q_CNT_W-1:0]          q_level;

  // Queue to back
  logic                        pop;
  logic                        head_valid;
  med3_tag_t                   head_tag;
  logic [COL_W-1:0]            head_col;
  logic [8:0][PIXEL_BITS-1:0]  head_win;

  // Classify each request, keep line stores and the window
  med3_front #(
    .MAX_LINE   (MAX_LINE),
    .PIXEL_BITS (PIXEL_BITS),
    .COL_W      (COL_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pixel  (in_pixel_in),
    .q_level   (q_level),
    .push      (push),
    .push_tag  (push_tag),
    .push_col  (push_col),
    .push_win  (push_win)
  );

  // Hold jobs so that front and back stall on their own
  med3_queue #(
    .PIXEL_BITS (PIXEL_BITS),
    .COL_W      (COL_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_tag   (push_tag),
    .push_col   (push_col),
    .push_win   (push_win),
    .pop        (pop),
    .head_valid (head_valid),
    .head_tag   (head_tag),
    .head_col   (head_col),
    .head_win   (head_win),
    .level      (q_level)
  );

  // Expand jobs into results and compute the medians
  med3_back #(
    .PIXEL_BITS (PIXEL_BITS),
    .COL_W      (COL_W)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_tag      (head_tag),
    .head_col      (head_col),
    .head_win      (head_win),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_median    (out_median_out),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_run_last  (out_run_last),
    .out_frame_end (out_frame_end)
  );

endmodule

`default_nettype wire

// ===== rtl/core/med3_checker.sv =====
// ----------------------------------------------------------------------------
// med3_checker
// Port-level checks of the median filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module med3_checker
  import med3_pkg::*;
#(
  parameter int MAX_LINE   = 1024,
  parameter int PIXEL_BITS = 8,
  localparam int COL_W     = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   cfg_we,
  input wire logic [CFG_IDX_W-1:0]   cfg_index,
  input wire logic [CFG_W-1:0]       cfg_wdata,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic [PIXEL_BITS-1:0]  in_pixel_in,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [PIXEL_BITS-1:0]  out_median_out,
  input wire logic [ROW_W-1:0]       out_row,
  input wire logic [COL_W-1:0]       out_col,
  input wire logic                   out_run_last,
  input wire logic                   out_frame_end
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_median_out) &&
      $stable(out_row) && $stable(out_col) && $stable(out_run_last) &&
      $stable(out_frame_end))
    else $error("stalled result changed");

  // The frame's final pixel always closes its request's run
  a_fend_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_run_last)
    else $error("frame end without run end");

  // Results of one request leave back to back
  a_run_tight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_run_last |=> out_valid)
    else $error("gap inside a result run");

  // Drop any result on reset
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind median_filter_3x3_unit med3_checker #(
  .MAX_LINE   (MAX_LINE),
  .PIXEL_BITS (PIXEL_BITS)
) u_med3_checker (.*);

`default_nettype wire
